// ===== rtl/pli_pkg.sv =====
package pli_pkg;

    // transaction opcodes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BELOW     = 2'd1,
        ST_ABOVE     = 2'd2,
        ST_ZERO_SPAN = 2'd3
    } status_t;

    // register indexes
    localparam int REG_KNOT_COUNT = 0;
    localparam int KNOT_COUNT_W   = 7;

endpackage

// ===== rtl/pli_front.sv =====
module pli_front #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32,
    parameter int QW         = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [5:0]            s_knot_index,
    input  logic [TIME_BITS-1:0]  s_knot_time,
    input  logic [VALUE_BITS-1:0] s_knot_value,
    input  logic [TIME_BITS-1:0]  s_query_time,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic                  q_cmd,
    output logic [5:0]            q_index,
    output logic [TIME_BITS-1:0]  q_time,
    output logic [VALUE_BITS-1:0] q_value
);
    import pli_pkg::*;

    localparam int DEPTH = 1 << QW;
    localparam int ENT_W = 1 + 6 + TIME_BITS + VALUE_BITS;

    logic [ENT_W-1:0] fifo_reg [DEPTH];
    logic [QW-1:0]    wptr_reg, rptr_reg;
    logic [QW:0]      cnt_reg;
    logic             push, pop;
    logic [TIME_BITS-1:0] tsel;
    logic [ENT_W-1:0] head;

    // classify: writes carry knot time, queries carry the query time
    assign tsel    = (s_cmd == CMD_QUERY) ? s_query_time : s_knot_time;
    assign s_ready = (cnt_reg != DEPTH[QW:0]);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign head    = fifo_reg[rptr_reg];
    assign {q_cmd, q_index, q_time, q_value} = head;

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wptr_reg] <= {s_cmd, s_knot_index, tsel, s_knot_value};
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + {{QW{1'b0}}, push} - {{QW{1'b0}}, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH[QW:0]) else $error("queue overflow");
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == DEPTH[QW:0]) |-> !s_ready) else $error("ready while full");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("count slip");

endmodule

// ===== rtl/pli_back.sv =====
module pli_back #(
    parameter int MAX_KNOTS  = 64,
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [6:0]            knot_count,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic                  q_cmd,
    input  logic [5:0]            q_index,
    input  logic [TIME_BITS-1:0]  q_time,
    input  logic [VALUE_BITS-1:0] q_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_interp_value,
    output pli_pkg::status_t      m_status
);
    import pli_pkg::*;

    localparam int AW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW  = $clog2(MAX_KNOTS + 1);
    localparam int PW  = TIME_BITS + VALUE_BITS;
    localparam int DCW = $clog2(PW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CHK0, S_SRCH, S_RDV, S_CAPV, S_MUL, S_DIV, S_FIN, S_OUT
    } state_t;

    logic [TIME_BITS-1:0]  tmem [MAX_KNOTS];
    logic [VALUE_BITS-1:0] vmem [MAX_KNOTS];

    state_t                state_reg;
    logic [AW-1:0]         raddr_reg;
    logic [TIME_BITS-1:0]  trd_reg;
    logic [VALUE_BITS-1:0] vrd_reg;
    logic [TIME_BITS-1:0]  q_reg, t0_reg, t1_reg;
    logic [VALUE_BITS-1:0] v0_reg, v1_reg;
    logic [CW-1:0]         i_reg, n_reg;
    logic                  first_reg;
    logic [PW-1:0]         prod_reg;
    logic [TIME_BITS:0]    rem_reg;
    logic [PW-1:0]         quo_reg;
    logic [DCW-1:0]        dcnt_reg;
    logic                  m_valid_reg;
    logic [31:0]           val_reg;
    status_t               st_reg;
    logic [31:0]           wval_reg;
    status_t               wst_reg;
    logic [CW-1:0]         n_clamp;
    logic [TIME_BITS:0]    rem_sh, rem_sub;
    logic [TIME_BITS-1:0]  span;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] res;
    logic                  wr_ok;

    // clamp knot count to 2..MAX_KNOTS
    always_comb begin
        if (knot_count < 7'd2) n_clamp = CW'(2);
        else if (32'(knot_count) > MAX_KNOTS) n_clamp = CW'(MAX_KNOTS);
        else n_clamp = CW'(knot_count);
    end

    assign q_ready = (state_reg == S_IDLE);
    assign wr_ok   = q_valid && q_ready && (q_cmd == CMD_WRITE)
                     && (32'(q_index) < MAX_KNOTS);
    assign span    = t1_reg - t0_reg;
    assign mag     = (v1_reg >= v0_reg) ? v1_reg - v0_reg : v0_reg - v1_reg;
    assign rem_sh  = {rem_reg[TIME_BITS-1:0], prod_reg[PW-1]};
    assign rem_sub = rem_sh - {1'b0, span};
    assign res     = (v1_reg >= v0_reg) ? v0_reg + quo_reg[VALUE_BITS-1:0]
                                        : v0_reg - quo_reg[VALUE_BITS-1:0];

    // knot tables, registered read
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            tmem[AW'(q_index)] <= q_time;
            vmem[AW'(q_index)] <= q_value;
        end
        trd_reg <= tmem[raddr_reg];
        vrd_reg <= vmem[raddr_reg];
    end

    // query sequencer: linear search, multiply, restoring divide
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            raddr_reg   <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (q_valid && q_ready && q_cmd == CMD_QUERY) begin
                    q_reg     <= q_time;
                    n_reg     <= n_clamp;
                    raddr_reg <= '0;
                    state_reg <= S_RD0;
                end
                S_RD0: state_reg <= S_CHK0;
                S_CHK0: begin
                    t1_reg <= trd_reg;
                    if (q_reg < trd_reg) begin
                        wst_reg <= ST_BELOW; wval_reg <= '0; state_reg <= S_OUT;
                    end else begin
                        i_reg     <= CW'(1);
                        raddr_reg <= AW'(1);
                        first_reg <= 1'b1;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // first cycle waits for read data of the new address
                    if (first_reg) first_reg <= 1'b0;
                    else if (q_reg <= trd_reg) begin
                        t0_reg    <= t1_reg;
                        t1_reg    <= trd_reg;
                        v1_reg    <= vrd_reg;
                        raddr_reg <= raddr_reg - 1'b1;
                        first_reg <= 1'b1;
                        state_reg <= S_RDV;
                    end else if (i_reg + 1'b1 >= n_reg) begin
                        wst_reg <= ST_ABOVE; wval_reg <= '0; state_reg <= S_OUT;
                    end else begin
                        t1_reg    <= trd_reg;
                        i_reg     <= i_reg + 1'b1;
                        raddr_reg <= raddr_reg + 1'b1;
                        first_reg <= 1'b1;
                    end
                end
                S_RDV: begin
                    first_reg <= 1'b0;
                    if (!first_reg) state_reg <= S_CAPV;
                end
                S_CAPV: begin
                    v0_reg <= vrd_reg;
                    if (t1_reg <= t0_reg) begin
                        wst_reg <= ST_ZERO_SPAN; wval_reg <= '0; state_reg <= S_OUT;
                    end else state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= PW'(q_reg - t0_reg) * PW'(mag);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dcnt_reg  <= DCW'(PW);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    prod_reg <= prod_reg << 1;
                    if (!rem_sub[TIME_BITS]) begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCW'(1)) state_reg <= S_FIN;
                end
                S_FIN: begin
                    wval_reg  <= 32'(res);
                    wst_reg   <= ST_OK;
                    state_reg <= S_OUT;
                end
                // hand the finished result to the output register once it is free
                S_OUT: if (!m_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    val_reg     <= wval_reg;
                    st_reg      <= wst_reg;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_interp_value = val_reg;
    assign m_status       = st_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_interp_value))
        else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !q_ready) else $error("ready while busy");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_interp_value == '0))
        else $error("error with value");

endmodule

// ===== rtl/piecewise_linear_interpolator_top.sv =====
// query path: the queue, a linear search over the knot times, the value reads, a multiply
// and a restoring divide, one divide step a cycle; below the first knot, above the last knot
// or on a zero span the arithmetic is skipped and the status comes with value zero
// throughput: one query at a time in the back end, which takes a write from the 4-entry queue
// only when idle; the queue takes transactions meanwhile; a waiting result stalls the back end
// reset: aresetn synchronous active low clears control, knot_count to 2; tables undefined
module piecewise_linear_interpolator_top #(
    parameter int MAX_KNOTS  = 64,
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [0:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [5:0]            s_knot_index,
    input  logic [TIME_BITS-1:0]  s_knot_time,
    input  logic [VALUE_BITS-1:0] s_knot_value,
    input  logic [TIME_BITS-1:0]  s_query_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_interp_value,
    output logic [1:0]            m_status
);
    import pli_pkg::*;

    logic [KNOT_COUNT_W-1:0] knot_count_reg;
    logic                    q_valid, q_ready, q_cmd;
    logic [5:0]              q_index;
    logic [TIME_BITS-1:0]    q_time;
    logic [VALUE_BITS-1:0]   q_value;
    status_t                 st;

    // config register at paddr 0; writes to paddr 1 are ignored, reads return knot_count at either
    assign pready = 1'b1;
    assign prdata = {{(32-KNOT_COUNT_W){1'b0}}, knot_count_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) knot_count_reg <= KNOT_COUNT_W'(2);
        else if (psel && penable && pwrite && paddr == 1'(REG_KNOT_COUNT))
            knot_count_reg <= pwdata[KNOT_COUNT_W-1:0];
    end

    pli_front #(.TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS), .QW(2)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_knot_index, .s_knot_time,
        .s_knot_value, .s_query_time, .q_valid, .q_ready, .q_cmd, .q_index,
        .q_time, .q_value
    );

    pli_back #(.MAX_KNOTS(MAX_KNOTS), .TIME_BITS(TIME_BITS),
               .VALUE_BITS(VALUE_BITS)) u_back (
        .aclk, .aresetn, .knot_count(knot_count_reg), .q_valid, .q_ready, .q_cmd,
        .q_index, .q_time, .q_value, .m_valid, .m_ready, .m_interp_value,
        .m_status(st)
    );

    assign m_status = st;

endmodule

// ===== bench/pli_checker.sv =====
`timescale 1ns / 100ps

module pli_checker
    import pli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [5:0]  s_knot_index,
    input  logic [31:0] s_knot_time,
    input  logic [31:0] s_knot_value,
    input  logic [31:0] s_query_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_interp_value,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } interp_result_t;

    localparam int TABLE_DEPTH = 64;

    logic [31:0]    knot_t [TABLE_DEPTH];
    logic [31:0]    knot_v [TABLE_DEPTH];
    logic [6:0]     count_reg;
    interp_result_t results_due [$];

    // interpolate the table at one query time
    function automatic interp_result_t interpolate_at(input logic [31:0] q);
        interp_result_t r;
        int             n;
        int             seg;
        bit             hit;
        logic [63:0]    span, offs, mag, delta;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        r.value = '0;
        seg = 0;
        hit = 1'b0;
        if (q < knot_t[0]) begin
            r.status = ST_BELOW;
            return r;
        end
        for (int i = 1; i < n; i++) begin
            if (!hit && q <= knot_t[i]) begin
                seg = i - 1;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            r.status = ST_ABOVE;
            return r;
        end
        if (knot_t[seg+1] <= knot_t[seg]) begin
            r.status = ST_ZERO_SPAN;
            return r;
        end
        span  = 64'(knot_t[seg+1]) - 64'(knot_t[seg]);
        offs  = 64'(q) - 64'(knot_t[seg]);
        mag   = (knot_v[seg+1] >= knot_v[seg]) ? 64'(knot_v[seg+1] - knot_v[seg])
                                               : 64'(knot_v[seg] - knot_v[seg+1]);
        delta = (offs * mag) / span;
        r.value  = (knot_v[seg+1] >= knot_v[seg]) ? knot_v[seg] + delta[31:0]
                                                  : knot_v[seg] - delta[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    // track config, predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        interp_result_t want;
        if (!aresetn) begin
            count_reg = 7'd2;
            results_due.delete();
            fail_count <= 0;
            checked    <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 1'(REG_KNOT_COUNT))
                count_reg = pwdata[KNOT_COUNT_W-1:0];
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with none expected: value %h status %0d",
                           m_interp_value, m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    checked <= checked + 1;
                    if (m_interp_value !== want.value) begin
                        $error("interp_value expected %h actual %h",
                               want.value, m_interp_value);
                        fail_count <= fail_count + 1;
                    end else if (m_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_WRITE) begin
                    knot_t[s_knot_index] = s_knot_time;
                    knot_v[s_knot_index] = s_knot_value;
                end else begin
                    results_due.push_back(interpolate_at(s_query_time));
                end
            end
        end
        pending <= results_due.size();
    end

    initial begin
        pending    = 0;
        fail_count = 0;
        checked    = 0;
        count_reg  = 7'd2;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import pli_pkg::*;

    localparam int LIMIT = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite, pready;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_valid, s_ready, s_cmd;
    logic [5:0]  s_knot_index;
    logic [31:0] s_knot_time, s_knot_value, s_query_time;
    logic        m_valid, m_ready;
    logic [31:0] m_interp_value;
    logic [1:0]  m_status;

    int          fail_count, pending, checked;
    int          cycles;
    int          burst_left;
    int          sent;
    bit          hold_req;
    bit          hold_done;
    int          hold_cnt;
    int          rx_mode;
    logic [31:0] mirror_t [64];

    piecewise_linear_interpolator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_knot_index(s_knot_index), .s_knot_time(s_knot_time),
        .s_knot_value(s_knot_value), .s_query_time(s_query_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_interp_value(m_interp_value), .m_status(m_status)
    );

    pli_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_knot_index(s_knot_index), .s_knot_time(s_knot_time),
        .s_knot_value(s_knot_value), .s_query_time(s_query_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_interp_value(m_interp_value), .m_status(m_status),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("piecewise_linear_interpolator_top regression: fail");
            $finish;
        end
    end

    // receiver: random stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 3);
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= 1500;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 4) != 0);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // send one transaction, bursts separated by random gaps
    task automatic send_item(input logic cmd, input logic [5:0] idx, input logic [31:0] kt,
                             input logic [31:0] kv, input logic [31:0] q);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_knot_index <= idx;
        s_knot_time  <= kt;
        s_knot_value <= kv;
        s_query_time <= q;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_WRITE) mirror_t[idx] = kt;
        sent++;
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    // drain everything, then let a write still in flight settle
    task automatic wait_idle();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_knot_count(input logic [31:0] val);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'(REG_KNOT_COUNT);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // increasing table with random spacing, occasional repeated times
    task automatic load_table();
        int          shift;
        logic [63:0] acc;
        logic [63:0] gap;
        shift = $urandom_range(4, 25);
        acc   = $urandom_range(0, 1 << shift);
        for (int i = 0; i < 64; i++) begin
            send_item(CMD_WRITE, 6'(i), acc[31:0], $urandom, 32'h0);
            gap = ($urandom_range(0, 15) == 0) ? 64'd0 : 64'($urandom_range(1, 1 << shift));
            acc = acc + gap;
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        end
    endtask

    task automatic mixed_traffic(input int n_items, input int n_knots);
        int          seg;
        int          idx;
        logic [31:0] lo, hi, q;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                // rewrite one knot, mostly keeping order
                idx = $urandom_range(0, 63);
                lo  = (idx > 0) ? mirror_t[idx-1] : 32'h0;
                hi  = (idx < 63) ? mirror_t[idx+1] : 32'hFFFF_FFFF;
                if ($urandom_range(0, 4) == 0) lo = $urandom;
                send_item(CMD_WRITE, 6'(idx), $urandom_range(lo, hi), $urandom, $urandom);
            end else if ($urandom_range(0, 4) == 0) begin
                send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, $urandom);
            end else begin
                seg = $urandom_range(0, n_knots - 2);
                lo  = mirror_t[seg];
                hi  = mirror_t[seg+1];
                case ($urandom_range(0, 5))
                    0: q = lo;
                    1: q = hi;
                    default: q = $urandom_range(lo, hi);
                endcase
                send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, q);
            end
        end
    endtask

    initial begin
        int counts [8];
        int n_eff;
        aclk = 1'b0; aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_cmd = CMD_WRITE; s_knot_index = '0;
        s_knot_time = '0; s_knot_value = '0; s_query_time = '0;
        m_ready = 1'b0; cycles = 0; burst_left = 0; sent = 0;
        hold_req = 1'b0; hold_done = 1'b0; hold_cnt = 0; rx_mode = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: two-knot table at reset count, field extremes
        send_item(CMD_WRITE, 6'd0, 32'h0001_0000, 32'h0000_0000, 32'h0);
        send_item(CMD_WRITE, 6'd1, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_QUERY, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_FFFF);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_0001);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h8000_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h1234_5678);
        // decreasing values
        send_item(CMD_WRITE, 6'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_WRITE, 6'd1, 32'hFFFF_0000, 32'h0000_0000, 32'h0);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h8000_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0001);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_0000);
        // zero span, including a degenerate table at time zero
        send_item(CMD_WRITE, 6'd1, 32'h0001_0000, 32'h4000_0000, 32'h0);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0000);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0001);
        send_item(CMD_WRITE, 6'd0, 32'h0, 32'h1, 32'h0);
        send_item(CMD_WRITE, 6'd1, 32'h0, 32'h2, 32'h0);
        send_item(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0);

        // random phases across knot counts, clamped values among them
        counts = '{64, 2, 0, 1, 127, 33, 65, 0};
        counts[7] = $urandom_range(2, 64);
        for (int p = 0; p < 8; p++) begin
            set_knot_count(counts[p]);
            n_eff = (counts[p] < 2) ? 2 : (counts[p] > 64) ? 64 : counts[p];
            load_table();
            if (p == 1) hold_req = 1'b1;
            mixed_traffic(70, n_eff);
        end

        wait_idle();
        $display("sent %0d transactions over 8 knot-count settings, %0d results checked",
                 sent, checked);
        if (fail_count == 0)
            $display("piecewise_linear_interpolator_top regression: pass");
        else
            $display("piecewise_linear_interpolator_top regression: fail");
        $finish;
    end

endmodule
